>>> rtl/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared widths, constants and types of the triangle span rasterizer.
// ----------------------------------------------------------------------------
package tsr_pkg;

  localparam int COORD_W  = 10;
  localparam int COLOR_W  = 16;
  localparam int ADDR_W   = 20;
  localparam int STRIDE_W = 11;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STRIDE_W-1:0] stride_t;

  // Largest column value, also the "empty" minimum of a row
  localparam coord_t  COORD_MAX  = 10'h3ff;
  localparam stride_t STRIDE_RST = 11'd1024;

  // One vertex or one walked pixel
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Pixel stream from the edge walker
  typedef struct packed {
    logic   valid;
    point_t pt;
  } walk_pt_t;

  // Row table operations
  typedef enum logic [1:0] {
    TBL_NOP   = 2'd0,
    TBL_CLEAR = 2'd1,
    TBL_WIDEN = 2'd2,
    TBL_READ  = 2'd3
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e op;
    coord_t  row;
    coord_t  x;
  } tbl_req_t;

  // One entry of the row table
  typedef struct packed {
    coord_t x_min;
    coord_t x_max;
  } row_span_t;

endpackage

>>> rtl/tsr_edge_walker.sv
// ----------------------------------------------------------------------------
// tsr_edge_walker
// Bresenham walk over the edges a->b, b->c, c->a; one pixel per cycle.
// ----------------------------------------------------------------------------
module tsr_edge_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tsr_pkg::point_t     vert_i [3],
  output tsr_pkg::walk_pt_t   pt_o,
  output logic                active_o
);

  localparam int          ErrW     = 14;
  localparam int          DW       = tsr_pkg::COORD_W + 1;
  localparam logic [1:0]  LastEdge = 2'd2;

  // Walk state
  logic                   active_q, active_d;
  logic [1:0]             edge_q, edge_d;
  tsr_pkg::coord_t        x_q, x_d, y_q, y_d, x1_q, x1_d, y1_q, y1_d;
  logic [DW-1:0]          dx2_q, dx2_d, dy2_q, dy2_d;
  logic                   sxn_q, sxn_d, syn_q, syn_d, xmaj_q, xmaj_d;
  logic signed [ErrW-1:0] err_q, err_d;

  // Edge setup
  logic [1:0]             ld_sel;
  tsr_pkg::point_t        p0, p1;
  logic signed [DW-1:0]   dxs, dys;
  logic [DW-1:0]          adx, ady, ld_dx2, ld_dy2;
  logic                   ld_xmaj;
  logic signed [ErrW-1:0] ld_err;

  always_comb begin
    ld_sel = start_i ? 2'd0 : edge_q + 2'd1;
    unique case (ld_sel)
      2'd0: begin
        p0 = vert_i[0];
        p1 = vert_i[1];
      end
      2'd1: begin
        p0 = vert_i[1];
        p1 = vert_i[2];
      end
      default: begin
        p0 = vert_i[2];
        p1 = vert_i[0];
      end
    endcase
    dxs     = $signed({1'b0, p1.x}) - $signed({1'b0, p0.x});
    dys     = $signed({1'b0, p1.y}) - $signed({1'b0, p0.y});
    adx     = dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
    ady     = dys[DW-1] ? DW'(-dys) : DW'(dys);
    ld_dx2  = {adx[DW-2:0], 1'b0};
    ld_dy2  = {ady[DW-2:0], 1'b0};
    ld_xmaj = ld_dx2 > ld_dy2;
    ld_err  = ld_xmaj ? ($signed(ErrW'(ld_dy2)) - $signed(ErrW'(adx)))
                      : ($signed(ErrW'(ld_dx2)) - $signed(ErrW'(ady)));
  end

  // Step along the current edge
  logic at_end, err_pos;

  always_comb begin
    at_end   = xmaj_q ? (x_q == x1_q) : (y_q == y1_q);
    err_pos  = !err_q[ErrW-1];
    active_d = active_q;
    edge_d   = edge_q;
    x_d      = x_q;
    y_d      = y_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    dx2_d    = dx2_q;
    dy2_d    = dy2_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    xmaj_d   = xmaj_q;
    err_d    = err_q;
    if (start_i || (active_q && at_end && (edge_q != LastEdge))) begin
      active_d = 1'b1;
      edge_d   = ld_sel;
      x_d      = p0.x;
      y_d      = p0.y;
      x1_d     = p1.x;
      y1_d     = p1.y;
      dx2_d    = ld_dx2;
      dy2_d    = ld_dy2;
      sxn_d    = dxs[DW-1];
      syn_d    = dys[DW-1];
      xmaj_d   = ld_xmaj;
      err_d    = ld_err;
    end else if (active_q && at_end) begin
      active_d = 1'b0;
    end else if (active_q) begin
      if (xmaj_q) begin
        x_d   = sxn_q ? x_q - 1'b1 : x_q + 1'b1;
        if (err_pos) y_d = syn_q ? y_q - 1'b1 : y_q + 1'b1;
        err_d = err_q + $signed(ErrW'(dy2_q))
                - (err_pos ? $signed(ErrW'(dx2_q)) : '0);
      end else begin
        y_d   = syn_q ? y_q - 1'b1 : y_q + 1'b1;
        if (err_pos) x_d = sxn_q ? x_q - 1'b1 : x_q + 1'b1;
        err_d = err_q + $signed(ErrW'(dx2_q))
                - (err_pos ? $signed(ErrW'(dy2_q)) : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      edge_q   <= '0;
    end else begin
      active_q <= active_d;
      edge_q   <= edge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    dx2_q  <= dx2_d;
    dy2_q  <= dy2_d;
    sxn_q  <= sxn_d;
    syn_q  <= syn_d;
    xmaj_q <= xmaj_d;
    err_q  <= err_d;
  end

  // Current pixel goes out every active cycle
  assign pt_o.valid = active_q;
  assign pt_o.pt.x  = x_q;
  assign pt_o.pt.y  = y_q;
  assign active_o   = active_q;

endmodule

>>> rtl/tsr_row_table.sv
// ----------------------------------------------------------------------------
// tsr_row_table
// Per-row [min,max] column memory with a read-modify-write widen pipeline.
// ----------------------------------------------------------------------------
module tsr_row_table #(
  parameter int MAX_ROWS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsr_pkg::tbl_req_t   req_i,
  output tsr_pkg::row_span_t  rd_o,
  output logic                busy_o
);

  localparam int RowAw = $clog2(MAX_ROWS);

  // Memory, registered read
  tsr_pkg::row_span_t mem_q [MAX_ROWS];
  tsr_pkg::row_span_t rd_q;

  // Widen stage: read issued last cycle, data in rd_q now
  logic               s1_valid_q;
  logic [RowAw-1:0]   s1_row_q;
  tsr_pkg::coord_t    s1_x_q;

  // Last write, forwarded over the read-during-write gap
  logic               fwd_valid_q;
  logic [RowAw-1:0]   fwd_row_q;
  tsr_pkg::row_span_t fwd_data_q;

  tsr_pkg::row_span_t cur, upd, wdata, init_val;
  logic               we, re;
  logic [RowAw-1:0]   waddr, raddr;

  always_comb begin
    init_val.x_min = tsr_pkg::COORD_MAX;
    init_val.x_max = '0;
    cur = (fwd_valid_q && (fwd_row_q == s1_row_q)) ? fwd_data_q : rd_q;
    upd.x_min = (s1_x_q < cur.x_min) ? s1_x_q : cur.x_min;
    upd.x_max = (s1_x_q > cur.x_max) ? s1_x_q : cur.x_max;
    we    = s1_valid_q || (req_i.op == tsr_pkg::TBL_CLEAR);
    waddr = s1_valid_q ? s1_row_q : RowAw'(req_i.row);
    wdata = s1_valid_q ? upd : init_val;
    re    = (req_i.op == tsr_pkg::TBL_WIDEN) || (req_i.op == tsr_pkg::TBL_READ);
    raddr = RowAw'(req_i.row);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= (req_i.op == tsr_pkg::TBL_WIDEN);
      if (we) fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= RowAw'(req_i.row);
    s1_x_q   <= req_i.x;
    if (we) begin
      fwd_row_q  <= waddr;
      fwd_data_q <= wdata;
    end
  end

  assign rd_o   = rd_q;
  assign busy_o = s1_valid_q;

endmodule

>>> rtl/triangle_span_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_span_rasterizer
// Edge-walk triangle rasterizer that hands out one horizontal span per fetch.
// ----------------------------------------------------------------------------
//   channel  | handshake                  | carries
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid_i / in_stall_o    | req_type, three vertices, color
//   output   | out_valid_o / out_stall_i  | span row, start/end x, color, addr
//   config   | cfg_we_i / cfg_wdata_i     | row_stride
//
// A start clears one row a cycle over the rows spanned, then the walker
// widens the row of each walked pixel, one pixel a cycle, through the
// table's single read-modify-write port.
// A fetch reads the table, then multiplies out the address into the output
// register; it waits while the output register is held by out_stall_i.
// Reset clears control state only; the row table holds garbage until a start.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  tsr_pkg::stride_t         cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  tsr_pkg::coord_t          vert_a_x_i,
  input  tsr_pkg::coord_t          vert_a_y_i,
  input  tsr_pkg::coord_t          vert_b_x_i,
  input  tsr_pkg::coord_t          vert_b_y_i,
  input  tsr_pkg::coord_t          vert_c_x_i,
  input  tsr_pkg::coord_t          vert_c_y_i,
  input  tsr_pkg::color_t          fill_value_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     span_valid_o,
  output tsr_pkg::coord_t          span_row_o,
  output tsr_pkg::coord_t          span_x_start_o,
  output tsr_pkg::coord_t          span_x_end_o,
  output tsr_pkg::color_t          span_color_o,
  output tsr_pkg::addr_t           span_address_o,
  output logic                     last_span_o
);

  localparam int CoordMaxI = int'(tsr_pkg::COORD_MAX);
  localparam int ColLimI   = (MAX_COLS - 1 > CoordMaxI) ? CoordMaxI : MAX_COLS - 1;
  localparam int RowLimI   = (MAX_ROWS - 1 > CoordMaxI) ? CoordMaxI : MAX_ROWS - 1;
  localparam tsr_pkg::coord_t ColLim = tsr_pkg::coord_t'(ColLimI);
  localparam tsr_pkg::coord_t RowLim = tsr_pkg::coord_t'(RowLimI);
  localparam int ProdW = tsr_pkg::COORD_W + tsr_pkg::STRIDE_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FETCH = 2'd3;

  logic [1:0]         state_q, state_d;
  tsr_pkg::stride_t   stride_q;
  logic               pending_q, pending_d;
  logic               hit_q, hit_d;
  tsr_pkg::coord_t    next_row_q, next_row_d, final_row_q, final_row_d;
  tsr_pkg::coord_t    sweep_q, sweep_d;
  tsr_pkg::color_t    color_q, color_d;
  tsr_pkg::point_t    vert_q [3];
  tsr_pkg::point_t    vert_d [3];

  logic               out_valid_q, out_valid_d, out_load;
  logic               o_span_valid_q, o_last_q;
  tsr_pkg::coord_t    o_row_q, o_xs_q, o_xe_q;
  tsr_pkg::color_t    o_color_q;
  tsr_pkg::addr_t     o_addr_q;

  tsr_pkg::walk_pt_t  walk_pt;
  logic               walk_active, walk_start;
  tsr_pkg::tbl_req_t  tbl_req;
  tsr_pkg::row_span_t tbl_rd;
  logic               tbl_busy;

  logic               in_accept, out_free;
  tsr_pkg::point_t    cl [3];
  tsr_pkg::coord_t    lo, hi;
  logic [ProdW-1:0]   prod, addr_full;

  // Saturate incoming vertices and find the row range
  always_comb begin
    cl[0].x = (vert_a_x_i > ColLim) ? ColLim : vert_a_x_i;
    cl[0].y = (vert_a_y_i > RowLim) ? RowLim : vert_a_y_i;
    cl[1].x = (vert_b_x_i > ColLim) ? ColLim : vert_b_x_i;
    cl[1].y = (vert_b_y_i > RowLim) ? RowLim : vert_b_y_i;
    cl[2].x = (vert_c_x_i > ColLim) ? ColLim : vert_c_x_i;
    cl[2].y = (vert_c_y_i > RowLim) ? RowLim : vert_c_y_i;
    lo = cl[0].y;
    hi = cl[0].y;
    if (cl[1].y < lo) lo = cl[1].y;
    if (cl[2].y < lo) lo = cl[2].y;
    if (cl[1].y > hi) hi = cl[1].y;
    if (cl[2].y > hi) hi = cl[2].y;
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Address of the span start
  assign prod      = ProdW'(next_row_q) * ProdW'(stride_q);
  assign addr_full = prod + ProdW'(tbl_rd.x_min);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    hit_d       = hit_q;
    next_row_d  = next_row_q;
    final_row_d = final_row_q;
    sweep_d     = sweep_q;
    color_d     = color_q;
    vert_d      = vert_q;
    walk_start  = 1'b0;
    out_load    = 1'b0;
    tbl_req.op  = tsr_pkg::TBL_NOP;
    tbl_req.row = next_row_q;
    tbl_req.x   = walk_pt.pt.x;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && !req_type_i) begin
          vert_d      = cl;
          color_d     = fill_value_i;
          next_row_d  = lo;
          final_row_d = hi;
          sweep_d     = lo;
          pending_d   = 1'b1;
          state_d     = S_CLEAR;
        end else if (in_accept) begin
          hit_d   = pending_q;
          state_d = S_FETCH;
          if (pending_q) tbl_req.op = tsr_pkg::TBL_READ;
        end
      end
      S_CLEAR: begin
        tbl_req.op  = tsr_pkg::TBL_CLEAR;
        tbl_req.row = sweep_q;
        sweep_d     = sweep_q + 1'b1;
        if (sweep_q == final_row_q) begin
          walk_start = 1'b1;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        tbl_req.row = walk_pt.pt.y;
        if (walk_pt.valid) tbl_req.op = tsr_pkg::TBL_WIDEN;
        if (!walk_active && !tbl_busy) state_d = S_IDLE;
      end
      S_FETCH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (hit_q) begin
            if (next_row_q >= final_row_q) pending_d  = 1'b0;
            else                           next_row_d = next_row_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)              out_valid_d = 1'b1;
    else if (!out_stall_i)     out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stride_q    <= tsr_pkg::STRIDE_RST;
      pending_q   <= 1'b0;
      hit_q       <= 1'b0;
      next_row_q  <= '0;
      final_row_q <= '0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) stride_q <= cfg_wdata_i;
      pending_q   <= pending_d;
      hit_q       <= hit_d;
      next_row_q  <= next_row_d;
      final_row_q <= final_row_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sweep_q <= sweep_d;
    vert_q  <= vert_d;
    if (out_load) begin
      o_span_valid_q <= hit_q;
      o_row_q        <= hit_q ? next_row_q : '0;
      o_xs_q         <= hit_q ? tbl_rd.x_min : '0;
      o_xe_q         <= hit_q ? tbl_rd.x_max : '0;
      o_color_q      <= hit_q ? color_q : '0;
      o_addr_q       <= hit_q ? addr_full[tsr_pkg::ADDR_W-1:0] : '0;
      o_last_q       <= hit_q && (next_row_q >= final_row_q);
    end
  end

  tsr_edge_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (walk_start),
    .vert_i   (vert_q),
    .pt_o     (walk_pt),
    .active_o (walk_active)
  );

  tsr_row_table #(
    .MAX_ROWS (MAX_ROWS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rd_o   (tbl_rd),
    .busy_o (tbl_busy)
  );

  assign out_valid_o    = out_valid_q;
  assign span_valid_o   = o_span_valid_q;
  assign span_row_o     = o_row_q;
  assign span_x_start_o = o_xs_q;
  assign span_x_end_o   = o_xe_q;
  assign span_color_o   = o_color_q;
  assign span_address_o = o_addr_q;
  assign last_span_o    = o_last_q;

endmodule

>>> rtl/tsr_checker.sv
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks of the span rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module tsr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            req_type_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            span_valid_o,
  input tsr_pkg::coord_t span_row_o,
  input tsr_pkg::coord_t span_x_start_o,
  input tsr_pkg::coord_t span_x_end_o,
  input tsr_pkg::color_t span_color_o,
  input tsr_pkg::addr_t  span_address_o,
  input logic            last_span_o
);

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A stalled item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({span_valid_o, span_row_o,
      span_x_start_o, span_x_end_o, span_color_o, span_address_o, last_span_o}))
    else $error("output payload changed while stalled");

  // An empty fetch answer is all zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !span_valid_o |-> (span_row_o == '0) && (span_x_start_o == '0)
      && (span_x_end_o == '0) && (span_color_o == '0) && (span_address_o == '0)
      && !last_span_o)
    else $error("empty span item carries data");

  // A valid span starts at or left of its end: every row of a triangle has been touched by an edge
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && span_valid_o |-> span_x_start_o <= span_x_end_o)
    else $error("span start lies right of span end");

  // A start item occupies the block on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !req_type_i |=> in_stall_o)
    else $error("input taken again right after a start");

endmodule

bind triangle_span_rasterizer tsr_checker u_tsr_checker (.*);

>>> tb/triangle_span_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_span_rasterizer_tb
// Self-checking bench for the span rasterizer. A local row table and edge
// walk predict every span a fetch returns. Directed triangles cover points,
// lines, full-width rows and replacement of a pending triangle. Random phases
// then run at several row strides under bursty input and output stalls.
// ----------------------------------------------------------------------------
module triangle_span_rasterizer_tb;

  localparam int ROWS         = 1024;
  localparam int START_SETTLE = 4200;   // room for the clear pass and the walk of every edge
  localparam int IDLE_LIMIT   = 40000;
  localparam int PHASE_ITEMS  = 48;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_FETCH = 1'b1
  } req_e;

  typedef struct packed {
    logic            valid;
    tsr_pkg::coord_t row;
    tsr_pkg::coord_t xs;
    tsr_pkg::coord_t xe;
    tsr_pkg::color_t color;
    tsr_pkg::addr_t  addr;
    logic            last;
  } span_t;

  // DUT signals
  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  tsr_pkg::stride_t cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  req_e             req_type;
  tsr_pkg::coord_t  va_x, va_y, vb_x, vb_y, vc_x, vc_y;
  tsr_pkg::color_t  fill;
  logic             out_valid;
  logic             out_stall;
  logic             span_valid;
  tsr_pkg::coord_t  span_row, span_xs, span_xe;
  tsr_pkg::color_t  span_color;
  tsr_pkg::addr_t   span_addr;
  logic             span_last;

  // Predictor state
  tsr_pkg::coord_t  tbl_min [ROWS];
  tsr_pkg::coord_t  tbl_max [ROWS];
  int               cur_row;
  int               end_row;
  tsr_pkg::color_t  held_color_q;
  bit               spans_left;
  tsr_pkg::stride_t stride_q = tsr_pkg::STRIDE_RST;

  span_t   expected_spans[$];

  int      err_count   = 0;
  int      idle_cycles = 0;
  int      burst_left  = 0;
  bit      last_was_start = 1'b0;
  int      stall_hold  = 0;
  int      stall_mode  = 0;

  triangle_span_rasterizer DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .vert_a_x_i     (va_x),
    .vert_a_y_i     (va_y),
    .vert_b_x_i     (vb_x),
    .vert_b_y_i     (vb_y),
    .vert_c_x_i     (vc_x),
    .vert_c_y_i     (vc_y),
    .fill_value_i   (fill),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .span_valid_o   (span_valid),
    .span_row_o     (span_row),
    .span_x_start_o (span_xs),
    .span_x_end_o   (span_xe),
    .span_color_o   (span_color),
    .span_address_o (span_addr),
    .last_span_o    (span_last)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Pull a row's span out to cover column x
  function automatic void widen_row(int x, int y);
    tsr_pkg::coord_t xv;
    xv = tsr_pkg::coord_t'(x);
    if (y < 0 || y >= ROWS) return;
    if (xv < tbl_min[y]) tbl_min[y] = xv;
    if (xv > tbl_max[y]) tbl_max[y] = xv;
  endfunction

  // Integer line walk from (x0,y0) to (x1,y1), both ends included
  function automatic void trace_edge(int x0, int y0, int x1, int y1);
    int dx, dy, sx, sy, err;
    dx = x1 - x0;
    dy = y1 - y0;
    sx = 1;
    sy = 1;
    if (dy < 0) begin
      dy = -dy;
      sy = -1;
    end
    if (dx < 0) begin
      dx = -dx;
      sx = -1;
    end
    dx = dx * 2;
    dy = dy * 2;
    widen_row(x0, y0);
    if (dx > dy) begin
      err = dy - dx / 2;
      while (x0 != x1) begin
        if (err >= 0) begin
          y0 += sy;
          err -= dx;
        end
        x0 += sx;
        err += dy;
        widen_row(x0, y0);
      end
    end else begin
      err = dx - dy / 2;
      while (y0 != y1) begin
        if (err >= 0) begin
          x0 += sx;
          err -= dy;
        end
        y0 += sy;
        err += dx;
        widen_row(x0, y0);
      end
    end
  endfunction

  // Start: reset rows in range, then walk a->b, b->c, c->a
  function automatic void load_triangle(tsr_pkg::coord_t ax, tsr_pkg::coord_t ay,
                                        tsr_pkg::coord_t bx, tsr_pkg::coord_t by,
                                        tsr_pkg::coord_t cx, tsr_pkg::coord_t cy,
                                        tsr_pkg::color_t col);
    int lo, hi;
    lo = ay;
    hi = ay;
    if (by < lo) lo = by;
    if (cy < lo) lo = cy;
    if (by > hi) hi = by;
    if (cy > hi) hi = cy;
    for (int y = lo; y <= hi; y++) begin
      tbl_min[y] = tsr_pkg::COORD_MAX;
      tbl_max[y] = '0;
    end
    trace_edge(ax, ay, bx, by);
    trace_edge(bx, by, cx, cy);
    trace_edge(cx, cy, ax, ay);
    cur_row      = lo;
    end_row      = hi;
    held_color_q = col;
    spans_left   = 1'b1;
  endfunction

  // Fetch: next span top-down, all zero once the triangle is used up
  function automatic span_t next_span();
    span_t s;
    s = '0;
    if (!spans_left) return s;
    s.valid = 1'b1;
    s.row   = tsr_pkg::coord_t'(cur_row);
    s.xs    = tbl_min[cur_row];
    s.xe    = tbl_max[cur_row];
    s.color = held_color_q;
    s.addr  = tsr_pkg::addr_t'(cur_row * int'(stride_q) + int'(s.xs));
    s.last  = (cur_row >= end_row);
    if (s.last) spans_left = 1'b0;
    else cur_row++;
    return s;
  endfunction

  // ------------------------------------------------------------ driver tasks

  // One input item; bursts of random length with random gaps in between
  task automatic send_item(input req_e req, input tsr_pkg::coord_t ax,
                           input tsr_pkg::coord_t ay, input tsr_pkg::coord_t bx,
                           input tsr_pkg::coord_t by, input tsr_pkg::coord_t cx,
                           input tsr_pkg::coord_t cy, input tsr_pkg::color_t col);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= req;
    va_x     <= ax;
    va_y     <= ay;
    vb_x     <= bx;
    vb_y     <= by;
    vc_x     <= cx;
    vc_y     <= cy;
    fill     <= col;
    do @(posedge clk); while (in_stall);
    if (req == REQ_START) load_triangle(ax, ay, bx, by, cx, cy, col);
    else expected_spans.push_back(next_span());
    last_was_start = (req == REQ_START);
  endtask

  // Fetches carry random vertex and color bits that the block ignores
  task automatic fetch_spans(input int n);
    repeat (n)
      send_item(REQ_FETCH, tsr_pkg::coord_t'($urandom), tsr_pkg::coord_t'($urandom),
                tsr_pkg::coord_t'($urandom), tsr_pkg::coord_t'($urandom),
                tsr_pkg::coord_t'($urandom), tsr_pkg::coord_t'($urandom),
                tsr_pkg::color_t'($urandom));
  endtask

  // Hold off until every span is back and any start has finished its walk
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_spans.size() != 0) @(posedge clk);
    if (last_was_start) repeat (START_SETTLE) @(posedge clk);
    last_was_start = 1'b0;
  endtask

  task automatic set_stride(input tsr_pkg::stride_t value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stride_q  = value;
  endtask

  function automatic tsr_pkg::coord_t clip_coord(int v);
    if (v < 0) return '0;
    if (v > int'(tsr_pkg::COORD_MAX)) return tsr_pkg::COORD_MAX;
    return tsr_pkg::coord_t'(v);
  endfunction

  // Start followed mostly by a complete fetch run, sometimes cut short or overrun
  task automatic run_triangle_sequence(input bit wide, inout int sent);
    tsr_pkg::coord_t v[6];
    int              base_x, base_y, rows, n_fetch, pick;
    if (wide) begin
      foreach (v[i]) v[i] = tsr_pkg::coord_t'($urandom);
    end else begin
      base_x = $urandom_range(0, 1023);
      base_y = $urandom_range(0, 1023);
      for (int i = 0; i < 6; i += 2) begin
        v[i]   = clip_coord(base_x + int'($urandom_range(0, 14)) - 7);
        v[i+1] = clip_coord(base_y + int'($urandom_range(0, 14)) - 7);
      end
    end
    send_item(REQ_START, v[0], v[1], v[2], v[3], v[4], v[5],
              tsr_pkg::color_t'($urandom));
    rows = end_row - cur_row + 1;
    pick = $urandom_range(0, 99);
    if (wide && rows > 40) n_fetch = $urandom_range(1, 6);
    else if (pick < 70) n_fetch = rows;
    else if (pick < 82) n_fetch = rows + 1;
    else if (pick < 94) n_fetch = $urandom_range(0, rows - 1);
    else n_fetch = rows + $urandom_range(2, 4);
    fetch_spans(n_fetch);
    sent += 1 + n_fetch;
  endtask

  // -------------------------------------------------------------- test tasks

  // Fetch before any triangle: all-zero span
  task automatic test_empty_fetch();
    fetch_spans(1);
  endtask

  // Points and lines at the corners of the screen, and a full-width line on row 512
  task automatic test_degenerate();
    send_item(REQ_START, '0, '0, '0, '0, '0, '0, 16'h0000);
    fetch_spans(2);
    send_item(REQ_START, tsr_pkg::COORD_MAX, tsr_pkg::COORD_MAX, tsr_pkg::COORD_MAX,
              tsr_pkg::COORD_MAX, tsr_pkg::COORD_MAX, tsr_pkg::COORD_MAX, 16'hFFFF);
    fetch_spans(1);
    send_item(REQ_START, '0, 10'd512, tsr_pkg::COORD_MAX, 10'd512, '0, 10'd512, 16'h1234);
    fetch_spans(1);
    send_item(REQ_START, tsr_pkg::COORD_MAX, 10'd1020, tsr_pkg::COORD_MAX,
              tsr_pkg::COORD_MAX, tsr_pkg::COORD_MAX, 10'd1020, 16'h8001);
    fetch_spans(4);
  endtask

  // Full-width flat top, then one fetch past the end
  task automatic test_flat_wide();
    send_item(REQ_START, '0, 10'd5, tsr_pkg::COORD_MAX, 10'd5, 10'd511, 10'd9, 16'hA5C3);
    fetch_spans(6);
  endtask

  // A new start while spans are pending drops the old triangle
  task automatic test_replace();
    send_item(REQ_START, 10'd10, 10'd10, 10'd20, 10'd30, 10'd5, 10'd25, 16'h5A3C);
    fetch_spans(2);
    send_item(REQ_START, 10'd100, 10'd200, 10'd103, 10'd201, 10'd98, 10'd202, 16'h0F0F);
    fetch_spans(3);
  endtask

  // Random phases, one row stride each, extremes included
  task automatic test_random();
    tsr_pkg::stride_t strides[5];
    int               sent;
    strides = '{11'd1, 11'd0, 11'd2047, tsr_pkg::stride_t'($urandom_range(2, 1023)),
                tsr_pkg::STRIDE_RST};
    foreach (strides[p]) begin
      set_stride(strides[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0) wait_drained();
        run_triangle_sequence($urandom_range(0, 9) == 0, sent);
      end
    end
  endtask

  // ------------------------------------------------------------- monitors

  // Output stall in modes: open, random, mostly stalled
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_hold <= $urandom_range(16, 96);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each accepted span with the oldest prediction
  always @(posedge clk) begin : check_span
    span_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        $error("unexpected span item, row %0d", span_row);
        err_count++;
      end else begin
        want = expected_spans.pop_front();
        if (span_valid !== want.valid) begin
          $error("span_valid expected %0d got %0d", want.valid, span_valid);
          err_count++;
        end
        if (span_row !== want.row) begin
          $error("span_row expected %0d got %0d", want.row, span_row);
          err_count++;
        end
        if (span_xs !== want.xs) begin
          $error("span_x_start expected %0d got %0d", want.xs, span_xs);
          err_count++;
        end
        if (span_xe !== want.xe) begin
          $error("span_x_end expected %0d got %0d", want.xe, span_xe);
          err_count++;
        end
        if (span_color !== want.color) begin
          $error("span_color expected %h got %h", want.color, span_color);
          err_count++;
        end
        if (span_addr !== want.addr) begin
          $error("span_address expected %0d got %0d", want.addr, span_addr);
          err_count++;
        end
        if (span_last !== want.last) begin
          $error("last_span expected %0d got %0d", want.last, span_last);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[triangle_span_rasterizer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ------------------------------------------------------------------ main
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= tsr_pkg::STRIDE_RST;
    in_valid  <= 1'b0;
    req_type  <= REQ_START;
    va_x      <= '0;
    va_y      <= '0;
    vb_x      <= '0;
    vb_y      <= '0;
    vc_x      <= '0;
    vc_y      <= '0;
    fill      <= '0;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_fetch();
    test_degenerate();
    test_flat_wide();
    test_replace();
    test_random();

    wait_drained();
    repeat (16) @(posedge clk);
    if (expected_spans.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("[triangle_span_rasterizer] OK");
    end else begin
      $display("[triangle_span_rasterizer] ERROR");
    end
    $finish;
  end

endmodule
